// ----- rtl/ted_pkg.sv -----
// Shared widths, codes and types of the text encoding detector.
package ted_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int SCORE_W     = 26;
  localparam int HIST_DEPTH  = 7;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

  typedef logic [SCORE_W-1:0]     score_t;
  typedef logic [LENGTH_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    ENC_UNKNOWN = 3'd0,
    ENC_UTF16LE = 3'd1,
    ENC_UTF16BE = 3'd2,
    ENC_UTF8    = 3'd3,
    ENC_JIS     = 3'd4,
    ENC_ASCII   = 3'd5,
    ENC_SJIS    = 3'd6,
    ENC_EUCJP   = 3'd7
  } enc_t;

  typedef enum logic [1:0] {
    MARK_NONE    = 2'd0,
    MARK_UTF16LE = 2'd1,
    MARK_UTF16BE = 2'd2,
    MARK_UTF8    = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    ESC_UNDECIDED = 2'd0,
    ESC_FOUND     = 2'd1,
    ESC_ABORTED   = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    WIDE_NONE = 2'd0,
    WIDE_LE   = 2'd1,
    WIDE_BE   = 2'd2
  } wide_t;

  typedef enum logic [1:0] {
    EUC_NORMAL = 2'd0,
    EUC_SKIP   = 2'd1,
    EUC_PEND3  = 2'd2
  } euc_t;

  // Saturating add of a small increment to a score.
  function automatic score_t sat_add(input score_t s, input logic [1:0] d);
    logic [SCORE_W:0] sum;
    sum = {1'b0, s} + {{(SCORE_W-1){1'b0}}, d};
    if (sum > {1'b0, SCORE_MAX}) begin
      return SCORE_MAX;
    end
    return sum[SCORE_W-1:0];
  endfunction

  function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// ----- rtl/text_encoding_detector_unit.sv -----
// Top level of the text encoding detector: byte stream in, one verdict per buffer out.
// Usage:
//   in_*  : one byte of a text buffer per beat; in_tlast marks the final byte.
//   out_* : one verdict beat per buffer, out_tdata[2:0] = encoding
//           (0 unknown, 1 utf16le, 2 utf16be, 3 utf8, 4 jis, 5 ascii,
//           6 sjis, 7 eucjp).
//   Bytes are checked for a byte-order mark, JIS escapes, UTF-16 zero-byte
//   parity and pure ASCII, and scored as Shift-JIS, UTF-8 and EUC-JP sequences.
// Timing:
//   A byte is captured in an input register and folded into the detector
//   state when it leaves that register; the verdict for a buffer is written
//   to the result register as its last byte leaves the input register. One byte
//   per clock is sustained while no last byte waits for the result register.
// Reset:
//   rst_n low clears all detector state and the valid flags of the input and
//   result registers. After each verdict the state returns to its reset values.
// Stall:
//   While a verdict waits on out_tready, bytes that are not the last of a
//   buffer keep flowing; a last byte waits in the input register until the
//   result register is free.
module text_encoding_detector_unit
  import ted_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] encoding, [7:3] zero
);

  // Input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Detector state
  logic [7:0] hist_r [HIST_DEPTH];
  pos_t       pos_r;
  mark_t      mark_r,      mark_nxt;
  esc_t       esc_r,       esc_nxt;
  wide_t      wide_r,      wide_nxt;
  logic       non_ascii_r, non_ascii_nxt;
  logic       sj_skip_r,   sj_skip_nxt;
  logic       u8_skip_r,   u8_skip_nxt;
  euc_t       euc_r,       euc_nxt;
  score_t     sj_score_r,  sj_score_nxt;
  score_t     u8_score_r,  u8_score_nxt;
  score_t     euc_score_r, euc_score_nxt;

  // Result register
  logic       out_valid_r;
  enc_t       enc_r;
  enc_t       enc_nxt;

  logic out_free;
  logic advance;
  logic esc_hit;
  logic u8_skip_now;
  logic [7:0] b;
  logic [7:0] r0;
  logic [7:0] r1;

  assign out_free  = !out_valid_r || out_tready;
  // A byte moves into the state when its result, if any, has a slot.
  assign advance   = in_valid_r && (!last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, enc_r};

  assign b  = byte_r;
  assign r0 = hist_r[0];
  assign r1 = hist_r[1];

  // A JIS escape completed by the previous bytes (at least one byte follows it).
  always_comb begin
    esc_hit = 1'b0;
    if (pos_r >= pos_t'(3) && hist_r[2] == 8'h1B) begin
      if (hist_r[1] == 8'h28 &&
          (hist_r[0] == 8'h42 || hist_r[0] == 8'h4A || hist_r[0] == 8'h49)) begin
        esc_hit = 1'b1;
      end
      if (hist_r[1] == 8'h24 && (hist_r[0] == 8'h40 || hist_r[0] == 8'h42)) begin
        esc_hit = 1'b1;
      end
    end
    if (pos_r >= pos_t'(6) && hist_r[5] == 8'h1B && hist_r[4] == 8'h26 &&
        hist_r[3] == 8'h40 && hist_r[2] == 8'h1B && hist_r[1] == 8'h24 &&
        hist_r[0] == 8'h42) begin
      esc_hit = 1'b1;
    end
    if (pos_r >= pos_t'(4) && hist_r[3] == 8'h1B && hist_r[2] == 8'h24 &&
        hist_r[1] == 8'h28 && hist_r[0] == 8'h44) begin
      esc_hit = 1'b1;
    end
  end

  // Fold one byte into the detector state and form the verdict.
  always_comb begin
    mark_nxt      = mark_r;
    esc_nxt       = esc_r;
    wide_nxt      = wide_r;
    non_ascii_nxt = non_ascii_r;
    sj_skip_nxt   = sj_skip_r;
    u8_skip_nxt   = u8_skip_r;
    euc_nxt       = euc_r;
    sj_score_nxt  = sj_score_r;
    u8_score_nxt  = u8_score_r;
    euc_score_nxt = euc_score_r;
    u8_skip_now   = u8_skip_r;

    // Byte-order mark at the buffer start
    if (pos_r == pos_t'(1)) begin
      if (r0 == 8'hFF && b == 8'hFE) begin
        mark_nxt = MARK_UTF16LE;
      end else if (r0 == 8'hFE && b == 8'hFF) begin
        mark_nxt = MARK_UTF16BE;
      end
    end else if (pos_r == pos_t'(2) && mark_r == MARK_NONE) begin
      if (r1 == 8'hEF && r0 == 8'hBB && b == 8'hBF) begin
        mark_nxt = MARK_UTF8;
      end
    end

    // JIS escape search; a high byte while undecided aborts it
    if (esc_r == ESC_UNDECIDED) begin
      if (esc_hit) begin
        esc_nxt = ESC_FOUND;
      end else if (b > 8'h7F) begin
        esc_nxt = ESC_ABORTED;
      end
    end

    // UTF-16 zero-byte parity: even position of this byte means little endian
    if (pos_r != '0 && wide_r == WIDE_NONE && r0 == 8'h00 && b <= 8'h7F) begin
      wide_nxt = pos_r[0] ? WIDE_BE : WIDE_LE;
    end

    if (b == 8'h1B || b >= 8'h80) begin
      non_ascii_nxt = 1'b1;
    end

    if (pos_r != '0) begin
      // Shift-JIS pairs
      if (sj_skip_r) begin
        sj_skip_nxt = 1'b0;
      end else if ((in_rng(r0, 8'h81, 8'h9F) || in_rng(r0, 8'hE0, 8'hFC)) &&
                   (in_rng(b, 8'h40, 8'h7E) || in_rng(b, 8'h80, 8'hFC))) begin
        sj_score_nxt = sat_add(sj_score_r, 2'd2);
        sj_skip_nxt  = 1'b1;
      end

      // UTF-8: a three-byte hit suppresses a two-byte hit on the same byte
      u8_skip_nxt = 1'b0;
      if (pos_r >= pos_t'(2) && in_rng(r1, 8'hE0, 8'hEF) &&
          in_rng(r0, 8'h80, 8'hBF) && in_rng(b, 8'h80, 8'hBF)) begin
        u8_score_nxt = sat_add(u8_score_r, 2'd3);
        u8_skip_now  = 1'b1;
      end
      if (!u8_skip_now && in_rng(r0, 8'hC0, 8'hDF) && in_rng(b, 8'h80, 8'hBF)) begin
        u8_score_nxt = sat_add(u8_score_r, 2'd2);
        u8_skip_nxt  = 1'b1;
      end

      // EUC-JP
      if (euc_r == EUC_SKIP) begin
        euc_nxt = EUC_NORMAL;
      end else if (euc_r == EUC_PEND3 && in_rng(b, 8'hA1, 8'hFE)) begin
        euc_score_nxt = sat_add(euc_score_r, 2'd3);
        euc_nxt       = EUC_SKIP;
      end else begin
        euc_nxt = EUC_NORMAL;
        if ((in_rng(r0, 8'hA1, 8'hFE) && in_rng(b, 8'hA1, 8'hFE)) ||
            (r0 == 8'h8E && in_rng(b, 8'hA1, 8'hDF))) begin
          euc_score_nxt = sat_add(euc_score_r, 2'd2);
          euc_nxt       = EUC_SKIP;
        end else if (r0 == 8'h8F && in_rng(b, 8'hA1, 8'hFE)) begin
          euc_nxt = EUC_PEND3;
        end
      end
    end

    // Verdict in priority order; a tie for the top score gives unknown
    if (mark_nxt != MARK_NONE) begin
      unique case (mark_nxt)
        MARK_UTF16LE: enc_nxt = ENC_UTF16LE;
        MARK_UTF16BE: enc_nxt = ENC_UTF16BE;
        default:      enc_nxt = ENC_UTF8;
      endcase
    end else if (esc_nxt == ESC_FOUND) begin
      enc_nxt = ENC_JIS;
    end else if (wide_nxt == WIDE_LE) begin
      enc_nxt = ENC_UTF16LE;
    end else if (wide_nxt == WIDE_BE) begin
      enc_nxt = ENC_UTF16BE;
    end else if (!non_ascii_nxt) begin
      enc_nxt = ENC_ASCII;
    end else if (sj_score_nxt > euc_score_nxt && sj_score_nxt > u8_score_nxt) begin
      enc_nxt = ENC_SJIS;
    end else if (u8_score_nxt > euc_score_nxt && u8_score_nxt > sj_score_nxt) begin
      enc_nxt = ENC_UTF8;
    end else if (euc_score_nxt > sj_score_nxt && euc_score_nxt > u8_score_nxt) begin
      enc_nxt = ENC_EUCJP;
    end else begin
      enc_nxt = ENC_UNKNOWN;
    end
  end

  // Input register: take a beat whenever it is empty or the held byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Detector state: advance per byte, clear after the last byte of a buffer
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_r)) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= 8'h00;
      end
      pos_r       <= '0;
      mark_r      <= MARK_NONE;
      esc_r       <= ESC_UNDECIDED;
      wide_r      <= WIDE_NONE;
      non_ascii_r <= 1'b0;
      sj_skip_r   <= 1'b0;
      u8_skip_r   <= 1'b0;
      euc_r       <= EUC_NORMAL;
      sj_score_r  <= '0;
      u8_score_r  <= '0;
      euc_score_r <= '0;
    end else if (advance) begin
      hist_r[0] <= byte_r;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      if (pos_r != POS_MAX) begin
        pos_r <= pos_r + pos_t'(1);
      end
      mark_r      <= mark_nxt;
      esc_r       <= esc_nxt;
      wide_r      <= wide_nxt;
      non_ascii_r <= non_ascii_nxt;
      sj_skip_r   <= sj_skip_nxt;
      u8_skip_r   <= u8_skip_nxt;
      euc_r       <= euc_nxt;
      sj_score_r  <= sj_score_nxt;
      u8_score_r  <= u8_score_nxt;
      euc_score_r <= euc_score_nxt;
    end
  end

  // Result register: hold a verdict until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && last_r;
    end
    if (out_free && advance && last_r) begin
      enc_r <= enc_nxt;
    end
  end

endmodule
